[sv/assert_macros.svh]
// Assertion macros shared by the RTL; all sample on clock and mute during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle.
`define ASSERT_NOW(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Implication checked in the cycle after the premise.
`define ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[sv/c_esc_pkg.sv]
// Shared types and constants for the C escape sequence decoder.
`default_nettype none

package c_esc_pkg;

   localparam int unsigned LengthBitsDefault = 16;
   localparam int unsigned CountW            = 16;
   localparam int unsigned ByteW             = 8;

   typedef struct packed {
      logic [ByteW-1:0]  out_byte;
      logic              byte_valid;
      logic              done_res;
      logic              failed;
      logic [CountW-1:0] count;
   } rsp_type;

endpackage

`default_nettype wire

[sv/c_escape_sequence_decoder_unit.sv]
// Each result reaches rsp_* via the input register, then the result register.
// Throughput: one request per cycle while rsp_ready is high; decode is one short pass.
// An input register and a result register decouple the two sides; a request that
// yields no result (escape prefixes, dropped bytes) still passes the decode stage.
// Reset (synchronous, active high) empties both registers and returns to idle,
// outside any escape, with offset, length and hex nibble at zero.
`default_nettype none

module c_escape_sequence_decoder_unit import c_esc_pkg::*; #(
   parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel: one source byte per request
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [ByteW-1:0]  req_in_byte,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [ByteW-1:0]       rsp_out_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_done_res,
   output logic                   rsp_failed,
   output logic [CountW-1:0]      rsp_count
);

`include "assert_macros.svh"

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [ByteW-1:0] in_byte_ff;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff;

   logic             req_accept;
   logic             advance;     // held request moves through the decode step
   logic             produce;     // that step yields a result
   rsp_type          step_rsp;
   logic [2:0]       rsp_kind;    // byte, done, failed flags of the held result

   // decode may proceed whenever the result slot is free or being emptied
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   c_esc_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte_ff),
      .produce (produce),
      .result  (step_rsp)
   );

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = produce;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && produce) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_ff.out_byte;
   assign rsp_byte_valid = rsp_ff.byte_valid;
   assign rsp_done_res   = rsp_ff.done_res;
   assign rsp_failed     = rsp_ff.failed;
   assign rsp_count      = rsp_ff.count;
   assign rsp_kind       = {rsp_byte_valid, rsp_done_res, rsp_failed};

   // a result is exactly one of: decoded byte, string done, string failed
   `ASSERT_NOW(a_one_kind, !rsp_valid || $onehot(rsp_kind), "result kind not one-hot")
   // non-byte results carry a zero byte; byte results carry a zero count
   `ASSERT_NOW(a_byte_zero, !rsp_valid || rsp_byte_valid || rsp_out_byte == '0, "stray byte")
   `ASSERT_NOW(a_cnt_zero, !rsp_valid || !rsp_byte_valid || rsp_count == '0, "count on byte")
   // a held request is never lost while the decode stage is blocked
   `ASSERT_NEXT(a_hold_req, in_valid_ff && !advance, in_valid_ff, "held request dropped")

endmodule

`default_nettype wire

[sv/c_esc_core.sv]
// Per-byte decode step: escape state, counters and the result for one request.
`default_nettype none

module c_esc_core import c_esc_pkg::*; #(
   parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic [ByteW-1:0] in_byte,
   output logic                  produce,
   output rsp_type               result
);

   typedef enum logic [2:0] {
      PhIdle  = 3'd0,
      PhEsc   = 3'd1,
      PhHex1  = 3'd2,
      PhHex2  = 3'd3,
      PhDrain = 3'd4
   } phase_type;

   localparam logic [ByteW-1:0] ChNul   = 8'h00;
   localparam logic [ByteW-1:0] ChBksl  = 8'h5C;
   localparam logic [ByteW-1:0] ChDquo  = 8'h22;
   localparam logic [ByteW-1:0] ChSquo  = 8'h27;
   localparam logic [ByteW-1:0] ChN     = 8'h6E;
   localparam logic [ByteW-1:0] ChR     = 8'h72;
   localparam logic [ByteW-1:0] ChT     = 8'h74;
   localparam logic [ByteW-1:0] ChX     = 8'h78;
   localparam logic [ByteW-1:0] ChXUp   = 8'h58;
   localparam logic [ByteW-1:0] ChLf    = 8'h0A;
   localparam logic [ByteW-1:0] ChCr    = 8'h0D;
   localparam logic [ByteW-1:0] ChTab   = 8'h09;
   localparam logic [ByteW-1:0] ChSpace = 8'h20;
   localparam logic [ByteW-1:0] ChTilde = 8'h7E;
   localparam logic [ByteW-1:0] ChNine  = 8'h39;
   localparam logic [ByteW-1:0] HexAdj  = 8'h09;

   localparam logic [LENGTH_BITS-1:0] CntMax = '1;

   phase_type              phase_ff, phase_in;
   logic [3:0]             nib_ff, nib_in;
   logic [LENGTH_BITS-1:0] src_ff, src_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;

   logic [LENGTH_BITS-1:0] src_p1, src_p3, len_p1;
   logic                   is_hex;
   logic [3:0]             hex_val;
   logic [ByteW-1:0]       hex_sum;
   logic [ByteW-1:0]       esc_byte;
   logic                   esc_good;

   function automatic logic [LENGTH_BITS-1:0] sat_add(
      input logic [LENGTH_BITS-1:0] v,
      input logic [1:0]             k
   );
      logic [LENGTH_BITS:0] s;
      s = {1'b0, v} + {{(LENGTH_BITS-1){1'b0}}, k};
      return s[LENGTH_BITS] ? CntMax : s[LENGTH_BITS-1:0];
   endfunction

   function automatic logic [CountW-1:0] clamp(input logic [LENGTH_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000_FFFF) ? 16'hFFFF : w[CountW-1:0];
   endfunction

   assign src_p1  = sat_add(src_ff, 2'd1);
   assign src_p3  = sat_add(src_ff, 2'd3);
   assign len_p1  = sat_add(len_ff, 2'd1);
   assign is_hex  = in_byte inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
   assign hex_sum = (in_byte > ChNine) ? in_byte + HexAdj : in_byte;
   assign hex_val = hex_sum[3:0];

   always_comb begin
      esc_good = 1'b1;
      esc_byte = ChNul;
      case (in_byte)
         ChN:     esc_byte = ChLf;
         ChR:     esc_byte = ChCr;
         ChT:     esc_byte = ChTab;
         ChDquo:  esc_byte = ChDquo;
         ChSquo:  esc_byte = ChSquo;
         ChBksl:  esc_byte = ChBksl;
         default: esc_good = 1'b0;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      nib_in   = nib_ff;
      src_in   = src_ff;
      len_in   = len_ff;
      produce  = 1'b0;
      result   = '0;

      case (phase_ff)
         PhDrain: begin
            if (in_byte == ChNul) begin
               phase_in = PhIdle;
               nib_in   = '0;
               src_in   = '0;
               len_in   = '0;
            end
         end
         PhEsc: begin
            if (esc_good) begin
               phase_in          = PhIdle;
               src_in            = src_p1;
               len_in            = len_p1;
               produce           = 1'b1;
               result.out_byte   = esc_byte;
               result.byte_valid = 1'b1;
            end else if (in_byte == ChX || in_byte == ChXUp) begin
               phase_in = PhHex1;
            end else begin
               produce       = 1'b1;
               result.failed = 1'b1;
               result.count  = clamp(src_ff);
            end
         end
         PhHex1: begin
            if (is_hex) begin
               nib_in   = hex_val;
               phase_in = PhHex2;
            end else begin
               produce       = 1'b1;
               result.failed = 1'b1;
               result.count  = clamp(src_ff);
            end
         end
         PhHex2: begin
            if (is_hex) begin
               phase_in          = PhIdle;
               src_in            = src_p3;
               len_in            = len_p1;
               nib_in            = '0;
               produce           = 1'b1;
               result.out_byte   = {nib_ff, hex_val};
               result.byte_valid = 1'b1;
            end else begin
               produce       = 1'b1;
               result.failed = 1'b1;
               result.count  = clamp(src_ff);
            end
         end
         default: begin
            if (in_byte == ChNul) begin
               produce         = 1'b1;
               result.done_res = 1'b1;
               result.count    = clamp(len_ff);
               phase_in        = PhIdle;
               nib_in          = '0;
               src_in          = '0;
               len_in          = '0;
            end else if (in_byte == ChBksl) begin
               src_in   = src_p1;
               phase_in = PhEsc;
            end else if (in_byte inside {[ChSpace:ChTilde]}) begin
               phase_in          = PhIdle;
               src_in            = src_p1;
               len_in            = len_p1;
               produce           = 1'b1;
               result.out_byte   = in_byte;
               result.byte_valid = 1'b1;
            end else begin
               produce       = 1'b1;
               result.failed = 1'b1;
               result.count  = clamp(src_ff);
            end
         end
      endcase

      // any failure: a zero byte closes the string now, else drop to the terminator
      if (result.failed) begin
         if (in_byte == ChNul) begin
            phase_in = PhIdle;
            nib_in   = '0;
            src_in   = '0;
            len_in   = '0;
         end else begin
            phase_in = PhDrain;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhIdle;
         nib_ff   <= '0;
         src_ff   <= '0;
         len_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         nib_ff   <= nib_in;
         src_ff   <= src_in;
         len_ff   <= len_in;
      end
   end

endmodule

`default_nettype wire

[tb/unescape_tracker_pkg.sv]
// Order-keeping scoreboard for the escape decoder: predicts each result from the request stream.
package unescape_tracker_pkg;
   import c_esc_pkg::*;

   // characters that steer the decoder
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BSL    = "\\";
   localparam logic [7:0] CH_DQUOTE = "\"";
   localparam logic [7:0] CH_SQUOTE = "'";
   localparam logic [7:0] CH_N      = "n";
   localparam logic [7:0] CH_R      = "r";
   localparam logic [7:0] CH_T      = "t";
   localparam logic [7:0] CH_X_LO   = "x";
   localparam logic [7:0] CH_X_UP   = "X";
   localparam logic [7:0] CH_FIRST  = " ";
   localparam logic [7:0] CH_LAST   = "~";
   localparam logic [7:0] CTL_LF    = 8'h0a;
   localparam logic [7:0] CTL_CR    = 8'h0d;
   localparam logic [7:0] CTL_TAB   = 8'h09;

   localparam int unsigned REPORT_LIMIT = 40;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ESC,
      ST_HEX1,
      ST_HEX2,
      ST_DRAIN
   } esc_state_type;

   class unescape_tracker;
      esc_state_type     esc_state;
      logic [3:0]        hex_hi;
      longint unsigned   src_offset;
      longint unsigned   out_len;
      rsp_type           pending_results[$];
      int unsigned       requests;
      int unsigned       results;
      int unsigned       mismatches;

      function new();
         restart();
         requests   = 0;
         results    = 0;
         mismatches = 0;
      endfunction

      function void restart();
         esc_state  = ST_IDLE;
         hex_hi     = '0;
         src_offset = 0;
         out_len    = 0;
      endfunction

      function longint unsigned bump(longint unsigned v, int unsigned k);
         longint unsigned cap;
         cap = (64'd1 << LengthBitsDefault) - 1;
         return (v >= cap || cap - v < k) ? cap : v + k;
      endfunction

      function logic [CountW-1:0] clamp(longint unsigned v);
         return (v > 64'hffff) ? '1 : v[CountW-1:0];
      endfunction

      function bit is_hex(logic [7:0] c);
         return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
      endfunction

      function logic [3:0] nibble_of(logic [7:0] c);
         if (c <= "9") return 4'(c - "0");
         if (c >= "a") return 4'(c - "a" + 10);
         return 4'(c - "A" + 10);
      endfunction

      function void queue_result(logic [7:0] b, bit v, bit d, bit f, logic [CountW-1:0] n);
         rsp_type r;
         r.out_byte   = b;
         r.byte_valid = v;
         r.done_res   = d;
         r.failed     = f;
         r.count      = n;
         pending_results.push_back(r);
      endfunction

      function void queue_decoded(logic [7:0] b);
         out_len = bump(out_len, 1);
         queue_result(b, 1'b1, 1'b0, 1'b0, '0);
      endfunction

      // a zero byte ends the string at once, anything else starts the drop phase
      function void queue_fault(longint unsigned off, logic [7:0] c);
         if (c == CH_NUL) restart();
         else esc_state = ST_DRAIN;
         queue_result(8'h00, 1'b0, 1'b0, 1'b1, clamp(off));
      endfunction

      function void note_request(logic [7:0] c);
         logic [7:0]      d;
         bit              known;
         longint unsigned len;
         requests++;
         case (esc_state)
            ST_DRAIN: begin
               if (c == CH_NUL) restart();
            end
            ST_ESC: begin
               known = 1'b1;
               d     = c;
               case (c)
                  CH_N: d = CTL_LF;
                  CH_R: d = CTL_CR;
                  CH_T: d = CTL_TAB;
                  CH_DQUOTE, CH_SQUOTE, CH_BSL: d = c;
                  default: known = 1'b0;
               endcase
               if (c == CH_X_LO || c == CH_X_UP) begin
                  esc_state = ST_HEX1;
               end else if (known) begin
                  esc_state  = ST_IDLE;
                  src_offset = bump(src_offset, 1);
                  queue_decoded(d);
               end else begin
                  queue_fault(src_offset, c);
               end
            end
            ST_HEX1: begin
               if (!is_hex(c)) begin
                  queue_fault(src_offset, c);
               end else begin
                  hex_hi    = nibble_of(c);
                  esc_state = ST_HEX2;
               end
            end
            ST_HEX2: begin
               if (!is_hex(c)) begin
                  queue_fault(src_offset, c);
               end else begin
                  esc_state  = ST_IDLE;
                  src_offset = bump(src_offset, 3);
                  d          = {hex_hi, nibble_of(c)};
                  hex_hi     = '0;
                  queue_decoded(d);
               end
            end
            default: begin
               if (c == CH_NUL) begin
                  len = out_len;
                  restart();
                  queue_result(8'h00, 1'b0, 1'b1, 1'b0, clamp(len));
               end else if (c == CH_BSL) begin
                  src_offset = bump(src_offset, 1);
                  esc_state  = ST_ESC;
               end else if (c >= CH_FIRST && c <= CH_LAST) begin
                  esc_state  = ST_IDLE;
                  src_offset = bump(src_offset, 1);
                  queue_decoded(c);
               end else begin
                  queue_fault(src_offset, c);
               end
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         if (mismatches < REPORT_LIMIT) $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         results++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", results));
            return;
         end
         want = pending_results.pop_front();
         if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("result %0d out_byte %h, want %h",
                                      results, got.out_byte, want.out_byte));
         if (got.byte_valid !== want.byte_valid)
            report_mismatch($sformatf("result %0d byte_valid %b, want %b",
                                      results, got.byte_valid, want.byte_valid));
         if (got.done_res !== want.done_res)
            report_mismatch($sformatf("result %0d done_res %b, want %b",
                                      results, got.done_res, want.done_res));
         if (got.failed !== want.failed)
            report_mismatch($sformatf("result %0d failed %b, want %b",
                                      results, got.failed, want.failed));
         if (got.count !== want.count)
            report_mismatch($sformatf("result %0d count %0d, want %0d",
                                      results, got.count, want.count));
      endtask
   endclass

endpackage

[tb/testbench.sv]
// Top-level testbench for c_escape_sequence_decoder_unit: stimulus, handshakes and final verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import c_esc_pkg::*;
   import unescape_tracker_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int unsigned RANDOM_REQUESTS = 500;
   // length of the unbroken printable runs
   localparam int unsigned LONG_RUN        = 24;
   localparam int unsigned IDLE_PCT        = 34;
   localparam int unsigned HOLD_CYCLES     = 80;
   localparam int unsigned TAIL_CYCLES     = 20;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic [ByteW-1:0]     req_in_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic [ByteW-1:0]     rsp_out_byte;
   logic                 rsp_byte_valid;
   logic                 rsp_done_res;
   logic                 rsp_failed;
   logic [CountW-1:0]    rsp_count;

   int unsigned          req_idle_pct = IDLE_PCT;
   int unsigned          rsp_idle_pct = IDLE_PCT;
   int unsigned          hold_request = 0;
   int unsigned          hold_left    = 0;
   int unsigned          cycle_count  = 0;

   unescape_tracker      tracker = new();

   // directed strings: both printable extremes, the escapes n, t, double quote and backslash,
   // upper and lower hex with a zero byte decoded, a high byte followed by a dropped byte,
   // and a zero right after a backslash
   logic [7:0] directed[$] = '{
      CH_FIRST, CH_LAST, CH_BSL, CH_N, CH_BSL, CH_T, CH_BSL, CH_DQUOTE, CH_BSL, CH_BSL,
      CH_NUL,
      CH_BSL, CH_X_LO, "f", "F", CH_BSL, CH_X_UP, "0", "0", CH_NUL,
      8'hff, "a", CH_NUL,
      CH_BSL, CH_NUL
   };

   c_escape_sequence_decoder_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_done_res   (rsp_done_res),
      .rsp_failed     (rsp_failed),
      .rsp_count      (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a correct run ends far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due",
                  cycle_count, tracker.pending_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: random back-pressure, plus a long hold when the stimulus asks for one.
   // The hold is counted here so the sender keeps pushing requests meanwhile.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Every accepted result goes to the scoreboard; values here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result(rsp_type'{out_byte:   rsp_out_byte,
                                        byte_valid: rsp_byte_valid,
                                        done_res:   rsp_done_res,
                                        failed:     rsp_failed,
                                        count:      rsp_count});
   end

   // Offer one request, with random gaps in front, and hold it until accepted.
   // Valid stays high across back-to-back requests, so it gets one update per step.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(b);
   endtask

   // Sender goes quiet until every predicted result has been seen.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_results.size() != 0);
   endtask

   function automatic logic [7:0] rand_plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(126, 32)); while (c == CH_BSL);
      return c;
   endfunction

   function automatic logic [7:0] rand_hex_char();
      int unsigned v;
      v = $urandom_range(15);
      if (v < 10) return 8'("0" + v);
      return 8'((($urandom_range(1) != 0) ? "a" : "A") + v - 10);
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(255, 1));
      while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
      return c;
   endfunction

   function automatic logic [7:0] rand_x();
      return ($urandom_range(1) != 0) ? CH_X_LO : CH_X_UP;
   endfunction

   // A string of printable bytes, optionally closed by a bad escape, then the terminator.
   task automatic send_long_string(input int unsigned n, input bit close_with_fault);
      repeat (n) send_byte(rand_plain_char());
      if (close_with_fault) begin
         send_byte(CH_BSL);
         send_byte("q");
      end
      send_byte(CH_NUL);
   endtask

   // Random string: mostly well-formed pieces with random content; about one piece in five
   // breaks the string with a fault. Bytes after a fault are dropped by the block, so
   // they are left out of the live count.
   task automatic make_string(output logic [7:0] s[$], output int unsigned live);
      int unsigned pieces;
      int unsigned pick;
      int unsigned kind;
      int unsigned k;
      bit          broken;
      logic [7:0]  c;
      logic [7:0]  letters[6];
      letters = '{CH_N, CH_R, CH_T, CH_DQUOTE, CH_SQUOTE, CH_BSL};
      s       = {};
      broken  = 1'b0;
      kind    = 0;
      pieces  = $urandom_range(12);
      for (k = 0; k < pieces && !broken; k++) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            s.push_back(rand_plain_char());
         end else if (pick < 65) begin
            s.push_back(CH_BSL);
            s.push_back(letters[$urandom_range(5)]);
         end else if (pick < 82) begin
            s.push_back(CH_BSL);
            s.push_back(rand_x());
            s.push_back(rand_hex_char());
            s.push_back(rand_hex_char());
         end else begin
            broken = 1'b1;
            kind   = $urandom_range(4);
            case (kind)
               0: begin
                  // unknown escape letter
                  s.push_back(CH_BSL);
                  do c = 8'($urandom_range(255, 1));
                  while (c inside {CH_N, CH_R, CH_T, CH_DQUOTE, CH_SQUOTE, CH_BSL,
                                   CH_X_LO, CH_X_UP});
                  s.push_back(c);
               end
               1: begin
                  // control or high byte outside an escape
                  if ($urandom_range(1) != 0) s.push_back(8'($urandom_range(31, 1)));
                  else s.push_back(8'($urandom_range(255, 127)));
               end
               2: begin
                  s.push_back(CH_BSL);
                  s.push_back(rand_x());
                  s.push_back(rand_non_hex());
               end
               3: begin
                  s.push_back(CH_BSL);
                  s.push_back(rand_x());
                  s.push_back(rand_hex_char());
                  s.push_back(rand_non_hex());
               end
               default: begin
                  // string ends inside an escape: after the backslash, the x or one digit
                  pick = $urandom_range(2);
                  s.push_back(CH_BSL);
                  if (pick >= 1) s.push_back(rand_x());
                  if (pick == 2) s.push_back(rand_hex_char());
               end
            endcase
         end
      end
      live = s.size() + 1;
      if (broken && kind < 4)
         repeat ($urandom_range(4)) s.push_back(8'($urandom_range(255, 1)));
      s.push_back(CH_NUL);
   endtask

   initial begin
      logic [7:0]  str[$];
      int unsigned live;
      int unsigned random_live;
      int unsigned strings;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_byte(directed[i]);

      // Printable runs with no idling on either side: one closes cleanly, the
      // other ends in a bad escape.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_long_string(LONG_RUN, 1'b0);
      send_long_string(LONG_RUN, 1'b1);

      random_live = 0;
      strings     = 0;
      while (random_live < RANDOM_REQUESTS) begin
         if (strings == 12) begin
            // drain everything, then stall the result side while requests keep
            // coming, so the block fills up and drops req_ready
            wait_all_results();
            hold_request = HOLD_CYCLES;
            req_idle_pct = 0;
            send_long_string(40, 1'b0);
            wait_all_results();
         end
         // a stretch of strings with neither side idling
         req_idle_pct = (strings >= 25 && strings < 35) ? 0 : IDLE_PCT;
         rsp_idle_pct = req_idle_pct;
         make_string(str, live);
         foreach (str[i]) send_byte(str[i]);
         random_live += live;
         strings++;
      end

      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d requests and %0d results: directed escapes, %0d random strings",
               tracker.requests, tracker.results, strings);
      $display("with faults and truncated escapes, a held-off result side, and unbroken runs");
      if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/c_esc_pkg.sv
sv/c_esc_core.sv
sv/c_escape_sequence_decoder_unit.sv
tb/unescape_tracker_pkg.sv
tb/testbench.sv
